### rtl/target_position_guard_defines.svh
// Assertion macros shared by the target position guard RTL.
// Depends on nothing; users must have signals named clk and rst_n in scope.
`ifndef TARGET_POSITION_GUARD_DEFINES_SVH
`define TARGET_POSITION_GUARD_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define TPG_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define TPG_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/tpg_pkg.sv
// Shared types, constants and helpers of the target position guard.
// Used by tpg_ctrl, tpg_dpath and target_position_guard; depends on nothing.
package tpg_pkg;

    // Coordinate fields are read as the signed value of their low COORD_W bits.
    localparam int COORD_W = 32;
    // Working width of a position inside the datapath.
    localparam int PW = 40;

    // Index of the last of the three axes.
    localparam logic [1:0] LAST_AXIS = 2'd2;
    // Square root and division each retire one result bit per cycle.
    localparam logic [5:0] LAST_STEP = 6'd32;

    // Result outcome codes.
    localparam logic [2:0] OUTCOME_ACCEPTED     = 3'd0;
    localparam logic [2:0] OUTCOME_INV_HELD     = 3'd1;
    localparam logic [2:0] OUTCOME_INV_FALLBACK = 3'd2;
    localparam logic [2:0] OUTCOME_REJECTED     = 3'd3;
    localparam logic [2:0] OUTCOME_LIMITED      = 3'd4;

    typedef struct packed {
        logic signed [31:0] target_x;
        logic signed [31:0] target_y;
        logic signed [31:0] target_z;
        logic               target_invalid;
        logic signed [31:0] fallback_x;
        logic signed [31:0] fallback_y;
        logic signed [31:0] fallback_z;
        logic               restart;
    } tpg_in_t;

    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
        logic [2:0]         outcome;
        logic               box_clamped;
        logic               floor_raised;
    } tpg_out_t;

    // Configuration as seen by the datapath.
    typedef struct packed {
        logic [2:0][63:0] bounds;
        logic [30:0]      reject_threshold;
        logic [30:0]      max_step;
        logic [31:0]      floor_level;
        logic [62:0]      up_axis;
    } tpg_cfg_t;

    // Datapath operations issued by the controller.
    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD_TARGET,
        OP_LOAD_HELD,
        OP_LOAD_FALLBACK,
        OP_DELTA,
        OP_MUL,
        OP_ACC_D2,
        OP_CMP_REJ,
        OP_CMP_MAX,
        OP_SQRT_INIT,
        OP_SQRT_STEP,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_STEP_APPLY,
        OP_CLAMP,
        OP_ACC_S,
        OP_LIFT,
        OP_RAISE_APPLY,
        OP_STORE,
        OP_PUBLISH
    } tpg_op_t;

    // Operand selection of the shared multiplier.
    typedef enum logic [2:0] {
        MS_DD,
        MS_REJ,
        MS_MAX,
        MS_DMX,
        MS_UP,
        MS_LIFT
    } tpg_msel_t;

    typedef struct packed {
        tpg_op_t    op;
        tpg_msel_t  msel;
        logic [1:0] axis;
        logic [2:0] outcome;
    } tpg_cmd_t;

    typedef struct packed {
        logic rejected;
        logic limited;
        logic below_floor;
    } tpg_stat_t;

    // Sign-extend the low COORD_W bits of a coordinate field.
    function automatic logic signed [PW-1:0] sext_coord(input logic [31:0] v);
        logic signed [COORD_W-1:0] t;
        t = $signed(v[COORD_W-1:0]);
        return PW'(t);
    endfunction

endpackage

### rtl/tpg_dpath.sv
// Datapath of the target position guard: working registers, one shared multiplier,
// bit-serial square root and divider, clamps and the result register. Uses tpg_pkg.
module tpg_dpath
    import tpg_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  tpg_cmd_t  cmd,
    input  tpg_in_t   tgt,
    input  tpg_cfg_t  cfg,
    output tpg_stat_t stat,
    output tpg_out_t  res
);

    logic signed [PW-1:0] p_reg [3];
    logic signed [31:0]   h_reg [3];
    logic signed [32:0]   d_reg [3];
    logic [65:0]          acc_reg;
    logic [68:0]          prod_reg;
    logic                 prod_neg_reg;
    logic signed [55:0]   s_reg;
    logic [35:0]          lift_reg;
    logic [35:0]          sq_rem_reg;
    logic [32:0]          root_reg;
    logic [33:0]          div_rem_reg;
    logic [32:0]          quo_reg;
    logic                 rej_reg;
    logic                 lim_reg;
    logic                 boxed_reg;
    logic                 raised_reg;
    tpg_out_t             res_reg;

    // Clamp one coordinate to its box; the maximum wins when the bounds cross.
    function automatic logic signed [PW-1:0] clamp_one(
        input logic signed [PW-1:0] v,
        input logic [63:0]          b
    );
        logic signed [PW-1:0] lo;
        logic signed [PW-1:0] hi;
        logic signed [PW-1:0] r;
        lo = PW'($signed(b[31:0]));
        hi = PW'($signed(b[63:32]));
        r  = (v < lo) ? lo : v;
        r  = (r > hi) ? hi : r;
        return r;
    endfunction

    // Operands of the selected axis.
    logic signed [32:0]   d_sel;
    logic [32:0]          d_abs;
    logic signed [20:0]   u_sel;
    logic [20:0]          u_abs;
    logic signed [PW-1:0] p_sel;
    logic [PW-1:0]        p_abs;

    always_comb
    begin
        d_sel = d_reg[cmd.axis];
        d_abs = d_sel[32] ? 33'(-d_sel) : 33'(d_sel);
        u_sel = $signed(cfg.up_axis[21*cmd.axis +: 21]);
        u_abs = u_sel[20] ? 21'(-u_sel) : 21'(u_sel);
        p_sel = p_reg[cmd.axis];
        p_abs = p_sel[PW-1] ? PW'(-p_sel) : PW'(p_sel);
    end

    // Shared multiplier operand selection.
    logic [35:0] mul_a;
    logic [32:0] mul_b;
    logic        mul_neg;

    always_comb
    begin
        mul_a   = '0;
        mul_b   = '0;
        mul_neg = 1'b0;
        case (cmd.msel)
            MS_DD:
            begin
                mul_a = 36'(d_abs);
                mul_b = d_abs;
            end
            MS_REJ:
            begin
                mul_a = 36'(cfg.reject_threshold);
                mul_b = 33'(cfg.reject_threshold);
            end
            MS_MAX:
            begin
                mul_a = 36'(cfg.max_step);
                mul_b = 33'(cfg.max_step);
            end
            MS_DMX:
            begin
                mul_a = 36'(d_abs);
                mul_b = 33'(cfg.max_step);
            end
            MS_UP:
            begin
                mul_a   = 36'(u_abs);
                mul_b   = p_abs[32:0];
                mul_neg = u_sel[20] ^ p_sel[PW-1];
            end
            MS_LIFT:
            begin
                mul_a   = lift_reg;
                mul_b   = 33'(u_abs);
                mul_neg = u_sel[20];
            end
            default:
            begin
                mul_a = '0;
            end
        endcase
    end

    // Floor comparison against floor_level scaled to the dot-product format.
    logic signed [55:0] f_val;
    logic signed [55:0] lift_sum;
    logic [56:0]        raise_sum;
    logic [36:0]        raise_mag;

    always_comb
    begin
        f_val     = 56'($signed(cfg.floor_level)) <<< 19;
        lift_sum  = f_val - s_reg + 56'sd262144;
        raise_sum = 57'(prod_reg[55:0]) + 57'd262144;
        raise_mag = raise_sum[55:19];
    end

    // Square root and divider step values.
    logic [35:0] sq_trial_rem;
    logic [35:0] sq_trial;
    logic [33:0] div_trial_rem;

    always_comb
    begin
        sq_trial_rem  = {sq_rem_reg[33:0], acc_reg[65:64]};
        sq_trial      = {1'b0, root_reg, 2'b01};
        div_trial_rem = {div_rem_reg[32:0], quo_reg[32]};
    end

    // Held position: the only architectural state in the datapath.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                h_reg[i] <= '0;
            end
        end
        else if (cmd.op == OP_STORE)
        begin
            for (int i = 0; i < 3; i++)
            begin
                h_reg[i] <= p_reg[i][31:0];
            end
        end
    end

    // Working registers, updated by the issued operation.
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_LOAD_TARGET:
            begin
                p_reg[0]   <= sext_coord(tgt.target_x);
                p_reg[1]   <= sext_coord(tgt.target_y);
                p_reg[2]   <= sext_coord(tgt.target_z);
                boxed_reg  <= 1'b0;
                raised_reg <= 1'b0;
            end
            OP_LOAD_HELD:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    p_reg[i] <= PW'(h_reg[i]);
                end
                boxed_reg  <= 1'b0;
                raised_reg <= 1'b0;
            end
            OP_LOAD_FALLBACK:
            begin
                p_reg[0]   <= sext_coord(tgt.fallback_x);
                p_reg[1]   <= sext_coord(tgt.fallback_y);
                p_reg[2]   <= sext_coord(tgt.fallback_z);
                boxed_reg  <= 1'b0;
                raised_reg <= 1'b0;
            end
            OP_DELTA:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    d_reg[i] <= 33'(p_reg[i]) - 33'(h_reg[i]);
                end
                acc_reg <= '0;
            end
            OP_MUL:
            begin
                prod_reg     <= 69'(mul_a) * 69'(mul_b);
                prod_neg_reg <= mul_neg;
            end
            OP_ACC_D2:
            begin
                acc_reg <= acc_reg + prod_reg[65:0];
            end
            OP_CMP_REJ:
            begin
                rej_reg <= 69'(acc_reg) > prod_reg;
            end
            OP_CMP_MAX:
            begin
                lim_reg <= (69'(acc_reg) > prod_reg) && (acc_reg != '0);
            end
            OP_SQRT_INIT:
            begin
                sq_rem_reg <= '0;
                root_reg   <= '0;
            end
            OP_SQRT_STEP:
            begin
                // One root bit per cycle; the radicand shifts out two bits at a time.
                if (sq_trial_rem >= sq_trial)
                begin
                    sq_rem_reg <= sq_trial_rem - sq_trial;
                    root_reg   <= {root_reg[31:0], 1'b1};
                end
                else
                begin
                    sq_rem_reg <= sq_trial_rem;
                    root_reg   <= {root_reg[31:0], 1'b0};
                end
                acc_reg <= {acc_reg[63:0], 2'b00};
            end
            OP_DIV_INIT:
            begin
                // The quotient fits in 33 bits, so the upper dividend bits preload.
                div_rem_reg <= 34'(prod_reg[63:33]);
                quo_reg     <= prod_reg[32:0];
            end
            OP_DIV_STEP:
            begin
                if (div_trial_rem >= 34'(root_reg))
                begin
                    div_rem_reg <= div_trial_rem - 34'(root_reg);
                    quo_reg     <= {quo_reg[31:0], 1'b1};
                end
                else
                begin
                    div_rem_reg <= div_trial_rem;
                    quo_reg     <= {quo_reg[31:0], 1'b0};
                end
            end
            OP_STEP_APPLY:
            begin
                if (d_sel[32])
                begin
                    p_reg[cmd.axis] <= PW'(h_reg[cmd.axis]) - PW'(quo_reg);
                end
                else
                begin
                    p_reg[cmd.axis] <= PW'(h_reg[cmd.axis]) + PW'(quo_reg);
                end
            end
            OP_CLAMP:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    p_reg[i] <= clamp_one(p_reg[i], cfg.bounds[i]);
                end
                if ((clamp_one(p_reg[0], cfg.bounds[0]) != p_reg[0]) ||
                    (clamp_one(p_reg[1], cfg.bounds[1]) != p_reg[1]) ||
                    (clamp_one(p_reg[2], cfg.bounds[2]) != p_reg[2]))
                begin
                    boxed_reg <= 1'b1;
                end
                s_reg <= '0;
            end
            OP_ACC_S:
            begin
                if (prod_neg_reg)
                begin
                    s_reg <= s_reg - $signed(prod_reg[55:0]);
                end
                else
                begin
                    s_reg <= s_reg + $signed(prod_reg[55:0]);
                end
            end
            OP_LIFT:
            begin
                lift_reg   <= lift_sum[54:19];
                raised_reg <= 1'b1;
            end
            OP_RAISE_APPLY:
            begin
                if (prod_neg_reg)
                begin
                    p_reg[cmd.axis] <= p_sel - PW'(raise_mag);
                end
                else
                begin
                    p_reg[cmd.axis] <= p_sel + PW'(raise_mag);
                end
            end
            OP_PUBLISH:
            begin
                res_reg.out_x        <= p_reg[0][31:0];
                res_reg.out_y        <= p_reg[1][31:0];
                res_reg.out_z        <= p_reg[2][31:0];
                res_reg.outcome      <= cmd.outcome;
                res_reg.box_clamped  <= boxed_reg;
                res_reg.floor_raised <= raised_reg;
            end
            default:
            begin
                rej_reg <= rej_reg;
            end
        endcase
    end

    // Status back to the controller.
    assign stat.rejected    = rej_reg;
    assign stat.limited     = lim_reg;
    assign stat.below_floor = s_reg < f_val;
    assign res              = res_reg;

endmodule

### rtl/tpg_ctrl.sv
// Controller of the target position guard: sequences datapath operations per item
// and owns the handshakes and the held-valid flag. Uses tpg_pkg.
module tpg_ctrl
    import tpg_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      tgt_valid,
    input  logic      tgt_invalid,
    input  logic      tgt_restart,
    output logic      tgt_ready,
    output logic      res_valid,
    input  logic      res_ready,
    input  tpg_stat_t stat,
    output tpg_cmd_t  cmd
);

    typedef enum logic [4:0] {
        S_IDLE,
        S_DELTA,
        S_SQ_MUL,
        S_SQ_ACC,
        S_REJ_MUL,
        S_REJ_CMP,
        S_MAX_MUL,
        S_MAX_CMP,
        S_DECIDE,
        S_SQRT,
        S_DIV_MUL,
        S_DIV_INIT,
        S_DIV,
        S_DIV_APPLY,
        S_CLAMP1,
        S_UP_MUL,
        S_UP_ACC,
        S_FLOOR_CMP,
        S_RAISE_MUL,
        S_RAISE_ADD,
        S_CLAMP2,
        S_STORE,
        S_FINISH
    } state_t;

    state_t     state_reg, state_next;
    logic [1:0] axis_reg, axis_next;
    logic [5:0] cnt_reg, cnt_next;
    logic [2:0] outcome_reg, outcome_next;
    logic       held_valid_reg, held_valid_next;
    logic       res_valid_reg, res_valid_next;
    logic       held_now;

    // Next-state and command decode.
    always_comb
    begin
        state_next      = state_reg;
        axis_next       = axis_reg;
        cnt_next        = cnt_reg;
        outcome_next    = outcome_reg;
        held_valid_next = held_valid_reg;
        res_valid_next  = res_valid_reg && !res_ready;
        held_now        = held_valid_reg && !tgt_restart;
        cmd.op          = OP_NONE;
        cmd.msel        = MS_DD;
        cmd.axis        = axis_reg;
        cmd.outcome     = outcome_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (tgt_valid)
                begin
                    if (tgt_restart)
                    begin
                        held_valid_next = 1'b0;
                    end
                    if (tgt_invalid)
                    begin
                        cmd.op       = held_now ? OP_LOAD_HELD : OP_LOAD_FALLBACK;
                        outcome_next = held_now ? OUTCOME_INV_HELD : OUTCOME_INV_FALLBACK;
                        state_next   = S_FINISH;
                    end
                    else
                    begin
                        cmd.op       = OP_LOAD_TARGET;
                        outcome_next = OUTCOME_ACCEPTED;
                        state_next   = held_now ? S_DELTA : S_CLAMP1;
                    end
                end
            end
            S_DELTA:
            begin
                cmd.op     = OP_DELTA;
                axis_next  = '0;
                state_next = S_SQ_MUL;
            end
            S_SQ_MUL:
            begin
                cmd.op     = OP_MUL;
                cmd.msel   = MS_DD;
                state_next = S_SQ_ACC;
            end
            S_SQ_ACC:
            begin
                cmd.op = OP_ACC_D2;
                if (axis_reg == LAST_AXIS)
                begin
                    axis_next  = '0;
                    state_next = S_REJ_MUL;
                end
                else
                begin
                    axis_next  = axis_reg + 2'd1;
                    state_next = S_SQ_MUL;
                end
            end
            S_REJ_MUL:
            begin
                cmd.op     = OP_MUL;
                cmd.msel   = MS_REJ;
                state_next = S_REJ_CMP;
            end
            S_REJ_CMP:
            begin
                cmd.op     = OP_CMP_REJ;
                state_next = S_MAX_MUL;
            end
            S_MAX_MUL:
            begin
                cmd.op     = OP_MUL;
                cmd.msel   = MS_MAX;
                state_next = S_MAX_CMP;
            end
            S_MAX_CMP:
            begin
                cmd.op     = OP_CMP_MAX;
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                if (stat.rejected)
                begin
                    cmd.op       = OP_LOAD_HELD;
                    outcome_next = OUTCOME_REJECTED;
                    state_next   = S_CLAMP1;
                end
                else if (stat.limited)
                begin
                    cmd.op       = OP_SQRT_INIT;
                    outcome_next = OUTCOME_LIMITED;
                    cnt_next     = '0;
                    state_next   = S_SQRT;
                end
                else
                begin
                    state_next = S_CLAMP1;
                end
            end
            S_SQRT:
            begin
                cmd.op   = OP_SQRT_STEP;
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == LAST_STEP)
                begin
                    axis_next  = '0;
                    state_next = S_DIV_MUL;
                end
            end
            S_DIV_MUL:
            begin
                cmd.op     = OP_MUL;
                cmd.msel   = MS_DMX;
                state_next = S_DIV_INIT;
            end
            S_DIV_INIT:
            begin
                cmd.op     = OP_DIV_INIT;
                cnt_next   = '0;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                cmd.op   = OP_DIV_STEP;
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == LAST_STEP)
                begin
                    state_next = S_DIV_APPLY;
                end
            end
            S_DIV_APPLY:
            begin
                cmd.op = OP_STEP_APPLY;
                if (axis_reg == LAST_AXIS)
                begin
                    state_next = S_CLAMP1;
                end
                else
                begin
                    axis_next  = axis_reg + 2'd1;
                    state_next = S_DIV_MUL;
                end
            end
            S_CLAMP1:
            begin
                cmd.op     = OP_CLAMP;
                axis_next  = '0;
                state_next = S_UP_MUL;
            end
            S_UP_MUL:
            begin
                cmd.op     = OP_MUL;
                cmd.msel   = MS_UP;
                state_next = S_UP_ACC;
            end
            S_UP_ACC:
            begin
                cmd.op = OP_ACC_S;
                if (axis_reg == LAST_AXIS)
                begin
                    state_next = S_FLOOR_CMP;
                end
                else
                begin
                    axis_next  = axis_reg + 2'd1;
                    state_next = S_UP_MUL;
                end
            end
            S_FLOOR_CMP:
            begin
                if (stat.below_floor)
                begin
                    cmd.op     = OP_LIFT;
                    axis_next  = '0;
                    state_next = S_RAISE_MUL;
                end
                else
                begin
                    state_next = S_STORE;
                end
            end
            S_RAISE_MUL:
            begin
                cmd.op     = OP_MUL;
                cmd.msel   = MS_LIFT;
                state_next = S_RAISE_ADD;
            end
            S_RAISE_ADD:
            begin
                cmd.op = OP_RAISE_APPLY;
                if (axis_reg == LAST_AXIS)
                begin
                    state_next = S_CLAMP2;
                end
                else
                begin
                    axis_next  = axis_reg + 2'd1;
                    state_next = S_RAISE_MUL;
                end
            end
            S_CLAMP2:
            begin
                cmd.op     = OP_CLAMP;
                state_next = S_STORE;
            end
            S_STORE:
            begin
                cmd.op          = OP_STORE;
                held_valid_next = 1'b1;
                state_next      = S_FINISH;
            end
            S_FINISH:
            begin
                // Load the result register once it is empty or being emptied.
                if (!res_valid_reg || res_ready)
                begin
                    cmd.op         = OP_PUBLISH;
                    res_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            axis_reg       <= '0;
            cnt_reg        <= '0;
            outcome_reg    <= OUTCOME_ACCEPTED;
            held_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            axis_reg       <= axis_next;
            cnt_reg        <= cnt_next;
            outcome_reg    <= outcome_next;
            held_valid_reg <= held_valid_next;
            res_valid_reg  <= res_valid_next;
        end
    end

    assign tgt_ready = (state_reg == S_IDLE);
    assign res_valid = res_valid_reg;

endmodule

### rtl/target_position_guard.sv
// Top level of the target position guard: configuration registers, controller and datapath.
// Depends on tpg_pkg, tpg_ctrl, tpg_dpath and target_position_guard_defines.svh.
//
//   Channel   Signals                                  Beat
//   target    tgt_valid / tgt_ready / tgt              one requested position
//   result    res_valid / res_ready / res              one guarded position
//   config    psel penable pwrite paddr pwdata prdata  one 64-bit register access
//
// One item is in work at a time. An invalid target goes straight from accept to result; a valid
// target is clamped and floor-checked, after a check against the reject and max-step
// thresholds when a position is held; a limited step adds the square root and three divide
// passes, a floor lift a raise and a second clamp. A result that waits on res_ready holds the
// next item. The result register frees the target side: the next beat is taken while a result
// waits. Reset clears the held position, held-valid flag, control state and configuration to zero.
`include "target_position_guard_defines.svh"

module target_position_guard
    import tpg_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        tgt_valid,
    output logic        tgt_ready,
    input  tpg_in_t     tgt,
    output logic        res_valid,
    input  logic        res_ready,
    output tpg_out_t    res,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    localparam logic [2:0] REG_X_BOUNDS = 3'd0;
    localparam logic [2:0] REG_Y_BOUNDS = 3'd1;
    localparam logic [2:0] REG_Z_BOUNDS = 3'd2;
    localparam logic [2:0] REG_REJECT   = 3'd3;
    localparam logic [2:0] REG_MAX_STEP = 3'd4;
    localparam logic [2:0] REG_FLOOR    = 3'd5;
    localparam logic [2:0] REG_UP_AXIS  = 3'd6;

    tpg_cfg_t   cfg_reg;
    logic [2:0] reg_index;
    logic       cfg_write;

    assign pready    = 1'b1;
    assign reg_index = paddr[5:3];
    assign cfg_write = psel && penable && pwrite && pready;

    // Configuration register writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (reg_index)
                REG_X_BOUNDS: cfg_reg.bounds[0]        <= pwdata;
                REG_Y_BOUNDS: cfg_reg.bounds[1]        <= pwdata;
                REG_Z_BOUNDS: cfg_reg.bounds[2]        <= pwdata;
                REG_REJECT:   cfg_reg.reject_threshold <= pwdata[30:0];
                REG_MAX_STEP: cfg_reg.max_step         <= pwdata[30:0];
                REG_FLOOR:    cfg_reg.floor_level      <= pwdata[31:0];
                REG_UP_AXIS:  cfg_reg.up_axis          <= pwdata[62:0];
                default:      cfg_reg                  <= cfg_reg;
            endcase
        end
    end

    // Register read-back.
    always_comb
    begin
        case (reg_index)
            REG_X_BOUNDS: prdata = cfg_reg.bounds[0];
            REG_Y_BOUNDS: prdata = cfg_reg.bounds[1];
            REG_Z_BOUNDS: prdata = cfg_reg.bounds[2];
            REG_REJECT:   prdata = 64'(cfg_reg.reject_threshold);
            REG_MAX_STEP: prdata = 64'(cfg_reg.max_step);
            REG_FLOOR:    prdata = 64'(cfg_reg.floor_level);
            REG_UP_AXIS:  prdata = 64'(cfg_reg.up_axis);
            default:      prdata = '0;
        endcase
    end

    tpg_cmd_t  cmd;
    tpg_stat_t stat;

    tpg_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .tgt_valid   (tgt_valid),
        .tgt_invalid (tgt.target_invalid),
        .tgt_restart (tgt.restart),
        .tgt_ready   (tgt_ready),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .stat        (stat),
        .cmd         (cmd)
    );

    tpg_dpath u_dpath (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .tgt   (tgt),
        .cfg   (cfg_reg),
        .stat  (stat),
        .res   (res)
    );

    // One item at a time: an accepted beat closes the target side.
    `TPG_ASSERT_NEXT(a_one_in_flight, tgt_valid && tgt_ready, !tgt_ready, "second item taken while busy")
    // Invalid targets never report clamping or lifting.
    `TPG_ASSERT_SAME(a_invalid_flags, res_valid && (res.outcome == OUTCOME_INV_HELD || res.outcome == OUTCOME_INV_FALLBACK), !res.box_clamped && !res.floor_raised, "flags set on invalid target")
    // Only defined outcome codes are produced.
    `TPG_ASSERT_SAME(a_outcome_range, res_valid, res.outcome <= OUTCOME_LIMITED, "undefined outcome code")
    // A result appears only after the item has been worked on.
    `TPG_ASSERT_SAME(a_result_from_work, $rose(res_valid), !$past(tgt_ready), "result without work")

endmodule

### test/target_position_guard_tb.sv
// Self-checking testbench for target_position_guard: directed and random target beats are
// predicted by a local model of the guard and checked field by field. Depends on tpg_pkg.
module target_position_guard_tb;
    import tpg_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 250;

    // Register indexes of the configuration port.
    localparam int REG_X_BOUNDS   = 0;
    localparam int REG_Y_BOUNDS   = 1;
    localparam int REG_Z_BOUNDS   = 2;
    localparam int REG_REJECT     = 3;
    localparam int REG_MAX_STEP   = 4;
    localparam int REG_FLOOR      = 5;
    localparam int REG_UP_AXIS    = 6;

    logic        clk;
    logic        rst_n;
    logic        tgt_valid;
    logic        tgt_ready;
    tpg_in_t     tgt;
    logic        res_valid;
    logic        res_ready;
    tpg_out_t    res;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [5:0]  paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;

    // Shadow copy of the guard: configuration and held position.
    logic [63:0] bounds_q [3];
    logic [30:0] reject_q;
    logic [30:0] max_step_q;
    logic [31:0] floor_q;
    logic [62:0] up_q;
    longint      held_pos [3];
    bit          held_ok;

    tpg_out_t    expected_results [$];
    int          error_count;
    int          send_idle_pct;
    int          recv_idle_pct;
    int          quiet_cycles;

    target_position_guard DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .tgt_valid (tgt_valid),
        .tgt_ready (tgt_ready),
        .tgt       (tgt),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Clamp a position to the workspace box; min first, so max wins when they cross.
    function automatic bit clamp_to_box(inout longint p [3]);
        bit     changed;
        longint lo;
        longint hi;
        longint v;
        changed = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            lo = longint'($signed(bounds_q[i][31:0]));
            hi = longint'($signed(bounds_q[i][63:32]));
            v = p[i];
            if (v < lo) v = lo;
            if (v > hi) v = hi;
            if (v != p[i]) changed = 1'b1;
            p[i] = v;
        end
        return changed;
    endfunction

    function automatic logic [63:0] abs64(input longint v);
        return (v < 0) ? 64'(-v) : 64'(v);
    endfunction

    // Guarded position for one accepted target beat; advances the held position.
    function automatic tpg_out_t guard_position(input tpg_in_t item);
        tpg_out_t     r;
        longint       p [3];
        longint       d [3];
        longint       u [3];
        logic [127:0] d2;
        logic [127:0] cc;
        logic [63:0]  len;
        logic [63:0]  c;
        logic [127:0] q;
        logic [63:0]  lift;
        logic [63:0]  m;
        longint       s;
        longint       f;
        logic [2:0]   outcome;
        bit           boxed;
        bit           raised;
        outcome = OUTCOME_ACCEPTED;
        boxed = 1'b0;
        raised = 1'b0;
        if (item.restart) held_ok = 1'b0;
        if (item.target_invalid)
        begin
            p[0] = held_ok ? held_pos[0] : longint'(item.fallback_x);
            p[1] = held_ok ? held_pos[1] : longint'(item.fallback_y);
            p[2] = held_ok ? held_pos[2] : longint'(item.fallback_z);
            outcome = held_ok ? OUTCOME_INV_HELD : OUTCOME_INV_FALLBACK;
        end
        else
        begin
            p[0] = longint'(item.target_x);
            p[1] = longint'(item.target_y);
            p[2] = longint'(item.target_z);
            if (held_ok)
            begin
                d2 = '0;
                for (int i = 0; i < 3; i++)
                begin
                    d[i] = p[i] - held_pos[i];
                    d2 += 128'(abs64(d[i])) * 128'(abs64(d[i]));
                end
                if (d2 > 128'(reject_q) * 128'(reject_q))
                begin
                    outcome = OUTCOME_REJECTED;
                    for (int i = 0; i < 3; i++) p[i] = held_pos[i];
                end
                else if (d2 > 128'(max_step_q) * 128'(max_step_q) && d2 != 0)
                begin
                    // Integer square root, one bit at a time from the top.
                    len = '0;
                    for (int b = 53; b >= 0; b--)
                    begin
                        c = len | (64'd1 << b);
                        cc = 128'(c) * 128'(c);
                        if (cc <= d2) len = c;
                    end
                    outcome = OUTCOME_LIMITED;
                    for (int i = 0; i < 3; i++)
                    begin
                        q = (128'(abs64(d[i])) * 128'(max_step_q)) / 128'(len);
                        p[i] = held_pos[i] + ((d[i] < 0) ? -longint'(q[63:0])
                                                         : longint'(q[63:0]));
                    end
                end
            end
            boxed = clamp_to_box(p);

            // Floor check along the up row.
            for (int i = 0; i < 3; i++)
                u[i] = longint'($signed(up_q[21*i +: 21]));
            s = u[0] * p[0] + u[1] * p[1] + u[2] * p[2];
            f = longint'($signed(floor_q)) * 524288;
            if (s < f)
            begin
                lift = (64'(f - s) + 64'd262144) >> 19;
                raised = 1'b1;
                for (int i = 0; i < 3; i++)
                begin
                    m = (lift * abs64(u[i]) + 64'd262144) >> 19;
                    p[i] += (u[i] < 0) ? -longint'(m) : longint'(m);
                end
                if (clamp_to_box(p)) boxed = 1'b1;
            end
            for (int i = 0; i < 3; i++) held_pos[i] = p[i];
            held_ok = 1'b1;
        end
        r.out_x = p[0][31:0];
        r.out_y = p[1][31:0];
        r.out_z = p[2][31:0];
        r.outcome = outcome;
        r.box_clamped = boxed;
        r.floor_raised = raised;
        return r;
    endfunction

    // One register write: setup cycle, then access cycle.
    task automatic write_reg(input int idx, input logic [63:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= 6'(8 * idx);
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_X_BOUNDS, REG_Y_BOUNDS, REG_Z_BOUNDS: bounds_q[idx] = value;
            REG_REJECT:   reject_q = value[30:0];
            REG_MAX_STEP: max_step_q = value[30:0];
            REG_FLOOR:    floor_q = value[31:0];
            default:      up_q = value[62:0];
        endcase
    endtask

    task automatic write_all(input logic [63:0] xb, input logic [63:0] yb,
                             input logic [63:0] zb, input logic [30:0] rej,
                             input logic [30:0] mx, input logic [31:0] fl,
                             input logic [63:0] up);
        write_reg(REG_X_BOUNDS, xb);
        write_reg(REG_Y_BOUNDS, yb);
        write_reg(REG_Z_BOUNDS, zb);
        write_reg(REG_REJECT, 64'(rej));
        write_reg(REG_MAX_STEP, 64'(mx));
        write_reg(REG_FLOOR, 64'(fl));
        write_reg(REG_UP_AXIS, up);
    endtask

    // Send one target beat; valid stays high for a back-to-back beat.
    task automatic send_target(input tpg_in_t item);
        if ($urandom_range(99) < send_idle_pct)
        begin
            tgt_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle_pct) @(posedge clk);
        end
        tgt_valid <= 1'b1;
        tgt <= item;
        @(posedge clk);
        while (!tgt_ready) @(posedge clk);
        expected_results.push_back(guard_position(item));
    endtask

    // Wait until every expected result has come back and the block is quiet.
    task automatic drain();
        tgt_valid <= 1'b0;
        @(posedge clk);
        while (expected_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic tpg_in_t make_target(input logic [31:0] x, input logic [31:0] y,
                                            input logic [31:0] z, input bit invalid,
                                            input bit restart);
        tpg_in_t t;
        t.target_x = x;
        t.target_y = y;
        t.target_z = z;
        t.target_invalid = invalid;
        t.fallback_x = $urandom;
        t.fallback_y = $urandom;
        t.fallback_z = $urandom;
        t.restart = restart;
        return t;
    endfunction

    // Random offset from the held coordinate over a wide spread of magnitudes.
    function automatic logic [31:0] near_held(input int axis);
        logic signed [31:0] d;
        d = $signed($urandom) >>> $urandom_range(31, 4);
        return 32'(held_pos[axis] + longint'(d));
    endfunction

    function automatic logic [63:0] random_bounds();
        logic [31:0] a;
        logic [31:0] b;
        a = $urandom;
        b = $urandom;
        if ($urandom_range(9) != 0 && $signed(a) > $signed(b)) return {a, b};
        return {b, a};
    endfunction

    // Directed cases: each outcome, clamps, floor lift, restart, extremes.
    task automatic test_directed();
        write_all({32'h0400_0000, 32'hFC00_0000}, {32'h0400_0000, 32'hFC00_0000},
                  {32'h0400_0000, 32'hFC00_0000}, 31'h0100_0000, 31'h0010_0000,
                  32'hFF00_0000, {1'b1, 21'h08_0000, 21'd0, 21'd0});
        send_target(make_target(0, 0, 0, 1'b1, 1'b0));                 // fallback
        send_target(make_target(32'h0080_0000, 0, 0, 1'b0, 1'b0));    // nothing held
        send_target(make_target(0, 0, 0, 1'b1, 1'b0));                 // invalid held
        send_target(make_target(32'h0380_0000, 0, 0, 1'b0, 1'b0));    // jump rejected
        send_target(make_target(32'h00A0_0000, 32'h0008_0000, 32'hFFF0_0000, 1'b0, 1'b0));
        send_target(make_target(32'h00A0_0000, 32'h0008_0000, 32'hFFF0_0000, 1'b0, 1'b0));
        send_target(make_target(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 1'b1));
        send_target(make_target(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 1'b1));
        send_target(make_target(0, 0, 32'hF800_0000, 1'b0, 1'b1));     // below floor
        send_target(make_target(0, 0, 0, 1'b1, 1'b1));                 // restart, invalid
        drain();
        // Crossed box, zero up row with a high floor, zero thresholds.
        write_all({32'hFF00_0000, 32'h0100_0000}, {32'h8000_0000, 32'h7FFF_FFFF},
                  {32'h8000_0000, 32'h7FFF_FFFF}, 31'd0, 31'd0, 32'h7FFF_FFFF, 64'd0);
        send_target(make_target(32'h1234_5678, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 1'b1));
        send_target(make_target(32'h1234_5678, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 1'b0));
        send_target(make_target(32'h0, 32'h1, 32'h8000_0000, 1'b0, 1'b0));
        drain();
        // Widest thresholds and a tilted up row with negative entries.
        write_all({32'h7FFF_FFFF, 32'h8000_0000}, {32'h7FFF_FFFF, 32'h8000_0000},
                  {32'h7FFF_FFFF, 32'h8000_0000}, 31'h7FFF_FFFF, 31'h7FFF_FFFF,
                  32'h8000_0000, {1'b0, 21'h10_0000, 21'h0F_FFFF, 21'h1F_0000});
        send_target(make_target(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0, 1'b1));
        send_target(make_target(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, 1'b0));
        send_target(make_target(32'h0, 32'h0, 32'h0, 1'b0, 1'b0));
        drain();
        write_all({32'h7FFF_FFFF, 32'h8000_0000}, {32'h7FFF_FFFF, 32'h8000_0000},
                  {32'h7FFF_FFFF, 32'h8000_0000}, 31'h7FFF_FFFF, 31'h0000_0001,
                  32'h7FFF_FFFF, {1'b0, 21'h08_0000, 21'h08_0000, 21'h18_0000});
        send_target(make_target(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 1'b0));
        send_target(make_target(32'h0100_0000, 32'hFF00_0000, 32'h0000_0000, 1'b0, 1'b0));
        drain();
    endtask

    // Random beats: mostly steps near the held position, some restarts and noise.
    task automatic test_random(input int count, input int send_pct, input int recv_pct);
        tpg_in_t t;
        int      kind;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        write_all(random_bounds(), random_bounds(), random_bounds(),
                  31'($urandom) >> $urandom_range(30, 2), 31'($urandom) >> $urandom_range(30, 4),
                  $urandom >> $urandom_range(31, 0), {$urandom, $urandom});
        for (int n = 0; n < count; n++)
        begin
            kind = $urandom_range(99);
            if (kind < 70)
                t = make_target(near_held(0), near_held(1), near_held(2), 1'b0, 1'b0);
            else
                t = make_target($urandom, $urandom, $urandom, kind < 80, kind >= 90);
            send_target(t);
        end
        drain();
    endtask

    // Result checker and receiver stalls.
    always @(posedge clk)
    begin
        tpg_out_t want;
        if (rst_n && res_valid && res_ready)
        begin
            if (expected_results.size() == 0)
            begin
                $error("unexpected result beat: %p", res);
                error_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (res.out_x !== want.out_x)
                begin
                    $error("out_x expected %h actual %h", want.out_x, res.out_x);
                    error_count++;
                end
                if (res.out_y !== want.out_y)
                begin
                    $error("out_y expected %h actual %h", want.out_y, res.out_y);
                    error_count++;
                end
                if (res.out_z !== want.out_z)
                begin
                    $error("out_z expected %h actual %h", want.out_z, res.out_z);
                    error_count++;
                end
                if (res.outcome !== want.outcome)
                begin
                    $error("outcome expected %0d actual %0d", want.outcome, res.outcome);
                    error_count++;
                end
                if (res.box_clamped !== want.box_clamped)
                begin
                    $error("box_clamped expected %b actual %b", want.box_clamped,
                           res.box_clamped);
                    error_count++;
                end
                if (res.floor_raised !== want.floor_raised)
                begin
                    $error("floor_raised expected %b actual %b", want.floor_raised,
                           res.floor_raised);
                    error_count++;
                end
            end
        end
        res_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Watchdog on cycles with no beat accepted on either channel.
    always @(posedge clk)
    begin
        if ((tgt_valid && tgt_ready) || (res_valid && res_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("target_position_guard_tb: FAIL");
            $finish;
        end
    end

    // Test sequence.
    initial
    begin
        rst_n = 1'b0;
        tgt_valid = 1'b0;
        tgt = '0;
        res_ready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        quiet_cycles = 0;
        error_count = 0;
        send_idle_pct = 13;
        recv_idle_pct = 56;
        for (int i = 0; i < 3; i++)
        begin
            bounds_q[i] = '0;
            held_pos[i] = 0;
        end
        reject_q = '0;
        max_step_q = '0;
        floor_q = '0;
        up_q = '0;
        held_ok = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random(160, 13, 56);
        test_random(160, 56, 13);
        test_random(160, 0, 0);

        if (error_count == 0)
            $display("target_position_guard_tb: PASS");
        else
            $display("target_position_guard_tb: FAIL");
        $finish;
    end

endmodule

### files.f
+incdir+rtl
rtl/tpg_pkg.sv
rtl/tpg_dpath.sv
rtl/tpg_ctrl.sv
rtl/target_position_guard.sv
test/target_position_guard_tb.sv
